[hw/rtl/stereo_vu_meter_envelope_unit_assert.svh]
// Assertion macros for the VU meter envelope unit.
// Each macro expects clk_i and rst_ni in scope.
`ifndef STEREO_VU_METER_ENVELOPE_UNIT_ASSERT_SVH
`define STEREO_VU_METER_ENVELOPE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SVU_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("svu assertion failed");

// Next-cycle implication.
`define SVU_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("svu assertion failed");

`endif

[hw/rtl/svu_pkg.sv]
package svu_pkg;

  localparam int unsigned SampleW  = 10;
  localparam int unsigned LevelW   = 4;
  localparam int unsigned LedBarW  = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [SampleW-1:0] BaselineRst  = 10'd512;
  localparam logic [SampleW-1:0] FullScaleRst = 10'd192;
  localparam logic [SampleW-1:0] NoiseRst     = 10'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASELINE_LEFT  = 2'd0,
    CFG_BASELINE_RIGHT = 2'd1,
    CFG_FULL_SCALE     = 2'd2,
    CFG_NOISE_FLOOR    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [SampleW-1:0] left_sample;
    logic [SampleW-1:0] right_sample;
  } sample_t;

  typedef struct packed {
    logic [LevelW-1:0]  left_level;
    logic [LevelW-1:0]  right_level;
    logic [LedBarW-1:0] led_bar;
  } result_t;

  // One window entry holds both channel deviations.
  typedef struct packed {
    logic [SampleW-1:0] left_dev;
    logic [SampleW-1:0] right_dev;
  } dev_pair_t;

  function automatic logic [SampleW-1:0] rectify(logic [SampleW-1:0] s,
                                                 logic [SampleW-1:0] b);
    rectify = (s > b) ? (s - b) : (b - s);
  endfunction

endpackage

[hw/rtl/stereo_vu_meter_envelope_unit.sv]
// Stereo VU meter: each transfer of a left/right sample pair yields one result
// with both LED levels and the thermometer bar. The deviations are kept in a
// WINDOW_DEPTH-entry window memory with running sums; the mean and the LED
// scaling are each done by a bit-serial divider, one quotient bit per cycle,
// left and right in parallel. A new item is taken only once the result of the
// last one is stored in the output register, even while it still waits to be
// taken there, so input waits longer while the output stalls.
module stereo_vu_meter_envelope_unit #(
  parameter int unsigned WINDOW_DEPTH = 24,
  parameter int unsigned BAR_LEDS     = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  svu_pkg::sample_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output svu_pkg::result_t                 out_data_o,
  input  logic                             cfg_we_i,
  input  logic [svu_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [svu_pkg::CfgDataW-1:0]     cfg_data_i
);
  import svu_pkg::*;

  localparam int unsigned HalfLeds = BAR_LEDS / 2;
  localparam int unsigned LvlW     = $clog2(HalfLeds + 1);
  localparam int unsigned SumW     = $clog2(WINDOW_DEPTH * 1023 + 1);
  localparam int unsigned FillW    = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned PosW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned ProdW    = SampleW + LvlW;
  localparam int unsigned DivW     = (SumW > ProdW) ? SumW : ProdW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_SCALE_GO,
    ST_SCALE_WAIT,
    ST_OUT
  } state_e;

  state_e state_q;

  logic [SampleW-1:0] base_l_q, base_r_q, full_q, noise_q;
  logic [SampleW-1:0] dev_l_q, dev_r_q;
  logic [SampleW-1:0] mean_l_q, mean_r_q;
  logic               quiet_l_q, quiet_r_q;
  logic [LvlW-1:0]    lvl_l_q, lvl_r_q;
  logic [SumW-1:0]    sum_l_q, sum_r_q;
  logic [PosW-1:0]    pos_q;
  logic [FillW-1:0]   fill_q;
  logic               out_valid_q;
  result_t            out_data_q;

  logic               in_xfer;
  logic               window_full;
  dev_pair_t          rd_data;
  dev_pair_t          wr_data;
  logic [SampleW-1:0] old_l, old_r;
  logic               div_start;
  logic [DivW-1:0]    dvd_l, dvd_r;
  logic [SampleW-1:0] dvs;
  logic               done_l, done_r;
  logic [DivW-1:0]    quo_l, quo_r;
  logic [ProdW-1:0]   prod_l, prod_r;
  logic [LvlW-1:0]    sat_l, sat_r;
  result_t            bar_result;

  assign in_ready_o  = state_q == ST_IDLE;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign window_full = fill_q == FillW'(WINDOW_DEPTH);

  // Slots not yet written since reset count as zero.
  assign old_l = window_full ? rd_data.left_dev  : '0;
  assign old_r = window_full ? rd_data.right_dev : '0;

  assign wr_data.left_dev  = dev_l_q;
  assign wr_data.right_dev = dev_r_q;

  svu_window_mem #(
    .Depth (WINDOW_DEPTH),
    .AddrW (PosW)
  ) u_window (
    .clk_i     (clk_i),
    .rd_en_i   (in_xfer),
    .rd_addr_i (pos_q),
    .rd_data_o (rd_data),
    .wr_en_i   (state_q == ST_SUM),
    .wr_addr_i (pos_q),
    .wr_data_i (wr_data)
  );

  assign prod_l = ProdW'(mean_l_q) * ProdW'(HalfLeds);
  assign prod_r = ProdW'(mean_r_q) * ProdW'(HalfLeds);

  assign div_start = (state_q == ST_MEAN_GO) || (state_q == ST_SCALE_GO);
  assign dvd_l = (state_q == ST_MEAN_GO) ? DivW'(sum_l_q) : DivW'(prod_l);
  assign dvd_r = (state_q == ST_MEAN_GO) ? DivW'(sum_r_q) : DivW'(prod_r);
  assign dvs   = (state_q == ST_MEAN_GO) ? SampleW'(fill_q) : full_q;

  svu_divider #(
    .DividendW (DivW),
    .DivisorW  (SampleW)
  ) u_div_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_l),
    .divisor_i  (dvs),
    .done_o     (done_l),
    .quotient_o (quo_l)
  );

  svu_divider #(
    .DividendW (DivW),
    .DivisorW  (SampleW)
  ) u_div_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_r),
    .divisor_i  (dvs),
    .done_o     (done_r),
    .quotient_o (quo_r)
  );

  // Clamp the scaled level to half the bar.
  assign sat_l = (quo_l > DivW'(HalfLeds)) ? LvlW'(HalfLeds) : quo_l[LvlW-1:0];
  assign sat_r = (quo_r > DivW'(HalfLeds)) ? LvlW'(HalfLeds) : quo_r[LvlW-1:0];

  svu_bar #(
    .HalfLeds (HalfLeds),
    .LvlW     (LvlW)
  ) u_bar (
    .left_lvl_i  (lvl_l_q),
    .right_lvl_i (lvl_r_q),
    .result_o    (bar_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_l_q    <= BaselineRst;
      base_r_q    <= BaselineRst;
      full_q      <= FullScaleRst;
      noise_q     <= NoiseRst;
      sum_l_q     <= '0;
      sum_r_q     <= '0;
      pos_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CFG_BASELINE_LEFT:  base_l_q <= cfg_data_i;
          CFG_BASELINE_RIGHT: base_r_q <= cfg_data_i;
          CFG_FULL_SCALE:     full_q   <= cfg_data_i;
          CFG_NOISE_FLOOR:    noise_q  <= cfg_data_i;
          default: ;
        endcase
      end

      // In ST_OUT the register either loads now or still holds the older result.
      out_valid_q <= (state_q == ST_OUT) || (out_valid_q && !out_ready_i);

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          sum_l_q <= sum_l_q - SumW'(old_l) + SumW'(dev_l_q);
          sum_r_q <= sum_r_q - SumW'(old_r) + SumW'(dev_r_q);
          pos_q   <= (pos_q == PosW'(WINDOW_DEPTH - 1)) ? '0 : pos_q + 1'b1;
          if (!window_full) begin
            fill_q <= fill_q + 1'b1;
          end
          state_q <= ST_MEAN_GO;
        end
        ST_MEAN_GO: begin
          state_q <= ST_MEAN_WAIT;
        end
        ST_MEAN_WAIT: begin
          if (done_l) begin
            state_q <= ST_SCALE_GO;
          end
        end
        ST_SCALE_GO: begin
          state_q <= ST_SCALE_WAIT;
        end
        ST_SCALE_WAIT: begin
          if (done_l) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          // Hold the finished result until the output register frees up.
          if (!out_valid_q || out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      dev_l_q <= rectify(in_data_i.left_sample, base_l_q);
      dev_r_q <= rectify(in_data_i.right_sample, base_r_q);
    end
    if (state_q == ST_MEAN_WAIT && done_l) begin
      mean_l_q <= quo_l[SampleW-1:0];
      mean_r_q <= quo_r[SampleW-1:0];
    end
    if (state_q == ST_SCALE_GO) begin
      quiet_l_q <= mean_l_q < noise_q;
      quiet_r_q <= mean_r_q < noise_q;
    end
    if (state_q == ST_SCALE_WAIT && done_l) begin
      lvl_l_q <= quiet_l_q ? '0 : sat_l;
      lvl_r_q <= quiet_r_q ? '0 : sat_r;
    end
    if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
      out_data_q <= bar_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`include "stereo_vu_meter_envelope_unit_assert.svh"

  `SVU_ASSERT_NEXT(a_one_item_at_a_time, in_xfer, !in_ready_o)
  `SVU_ASSERT_NOW(a_fill_tracks_position, !window_full, pos_q == PosW'(fill_q))
  `SVU_ASSERT_NOW(a_dividers_in_step, done_l || done_r, done_l && done_r)
  `SVU_ASSERT_NOW(a_sum_bounded, 1'b1, sum_l_q <= SumW'(WINDOW_DEPTH * 1023))

endmodule

[hw/rtl/svu_window_mem.sv]
module svu_window_mem #(
  parameter int unsigned Depth = 24,
  parameter int unsigned AddrW = 5
) (
  input  logic               clk_i,
  input  logic               rd_en_i,
  input  logic [AddrW-1:0]   rd_addr_i,
  output svu_pkg::dev_pair_t rd_data_o,
  input  logic               wr_en_i,
  input  logic [AddrW-1:0]   wr_addr_i,
  input  svu_pkg::dev_pair_t wr_data_i
);
  import svu_pkg::*;

  dev_pair_t mem_q [Depth];
  dev_pair_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/svu_divider.sv]
module svu_divider #(
  parameter int unsigned DividendW = 16,
  parameter int unsigned DivisorW  = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [DividendW-1:0] quotient_o
);
  import svu_pkg::*;

  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  dvs_q, dvs_d;
  logic [DivisorW:0]    shifted;
  logic [DivisorW:0]    diff;
  logic                 ge;

  // One quotient bit per cycle, restoring form. A zero divisor yields all ones.
  assign shifted = {rem_q, quo_q[DividendW-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DividendW - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DividendW-2:0], ge};
      rem_d = ge ? diff[DivisorW-1:0] : shifted[DivisorW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[hw/rtl/svu_bar.sv]
module svu_bar #(
  parameter int unsigned HalfLeds = 8,
  parameter int unsigned LvlW     = 4
) (
  input  logic [LvlW-1:0]  left_lvl_i,
  input  logic [LvlW-1:0]  right_lvl_i,
  output svu_pkg::result_t result_o
);
  import svu_pkg::*;

  localparam int unsigned WideW = 2 * HalfLeds + LedBarW;

  logic [WideW-1:0]       wide;
  logic [LvlW+LevelW-1:0] left_ext;
  logic [LvlW+LevelW-1:0] right_ext;

  // Left thermometer in the low half, right thermometer right above it.
  always_comb begin
    wide = '0;
    for (int i = 0; i < HalfLeds; i++) begin
      wide[i]            = LvlW'(i) < left_lvl_i;
      wide[HalfLeds + i] = LvlW'(i) < right_lvl_i;
    end
  end

  assign left_ext  = (LvlW + LevelW)'(left_lvl_i);
  assign right_ext = (LvlW + LevelW)'(right_lvl_i);

  assign result_o.left_level  = left_ext[LevelW-1:0];
  assign result_o.right_level = right_ext[LevelW-1:0];
  assign result_o.led_bar     = wide[LedBarW-1:0];

endmodule

[test/stereo_vu_meter_envelope_unit_test.sv]
module stereo_vu_meter_envelope_unit_test;

  import svu_pkg::*;

  localparam int HalfLeds    = 8;
  localparam int WindowDepth = 24;

  typedef enum int {
    SHAPE_NOISE,
    SHAPE_SQUARE,
    SHAPE_RANDOM,
    SHAPE_RAILS,
    SHAPE_QUIET
  } shape_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  sample_t    in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  result_t    out_data_o;
  logic       cfg_we_i    = 1'b0;
  cfg_reg_e   cfg_idx_i   = CFG_BASELINE_LEFT;
  logic [9:0] cfg_data_i  = '0;

  stereo_vu_meter_envelope_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Meter state mirrored in the testbench
  logic [9:0]  baseline_l_reg = 10'd512;
  logic [9:0]  baseline_r_reg = 10'd512;
  logic [9:0]  full_scale_reg = 10'd192;
  logic [9:0]  noise_reg      = 10'd2;
  logic [9:0]  dev_l_hist [WindowDepth];
  logic [9:0]  dev_r_hist [WindowDepth];
  logic [14:0] sum_l = '0;
  logic [14:0] sum_r = '0;
  int          slot  = 0;
  int          seen  = 0;

  sample_t sample_queue [$];
  result_t levels_due [$];
  result_t want;
  int      outstanding = 0;
  int      mismatches  = 0;
  logic    in_taken    = 1'b0;
  logic    out_taken   = 1'b0;
  logic    idle_on     = 1'b1;
  logic    hold_off    = 1'b0;
  int      in_gap      = 0;
  int      out_wait    = 0;

  initial begin
    for (int i = 0; i < WindowDepth; i++) begin
      dev_l_hist[i] = '0;
      dev_r_hist[i] = '0;
    end
  end

  function automatic logic [9:0] deviation(logic [9:0] s, logic [9:0] b);
    return (s > b) ? s - b : b - s;
  endfunction

  function automatic int lit_leds(int mean);
    int scaled;
    if (mean < int'(noise_reg)) return 0;
    if (full_scale_reg == 0) return HalfLeds;
    scaled = (mean * HalfLeds) / int'(full_scale_reg);
    return (scaled > HalfLeds) ? HalfLeds : scaled;
  endfunction

  // Advance the window by one sample pair and return the meter reading.
  function automatic result_t meter_reading(sample_t s);
    logic [9:0] dl;
    logic [9:0] dr;
    int         ll;
    int         rl;
    result_t    r;
    dl = deviation(s.left_sample, baseline_l_reg);
    dr = deviation(s.right_sample, baseline_r_reg);
    sum_l = sum_l - 15'(dev_l_hist[slot]) + 15'(dl);
    sum_r = sum_r - 15'(dev_r_hist[slot]) + 15'(dr);
    dev_l_hist[slot] = dl;
    dev_r_hist[slot] = dr;
    slot = (slot + 1 >= WindowDepth) ? 0 : slot + 1;
    if (seen < WindowDepth) seen++;
    ll = lit_leds(int'(sum_l) / seen);
    rl = lit_leds(int'(sum_r) / seen);
    r.left_level  = 4'(ll);
    r.right_level = 4'(rl);
    r.led_bar     = 16'(((1 << ll) - 1) | (((1 << rl) - 1) << HalfLeds));
    return r;
  endfunction

  // Output check first, then record the expectation of a new input transfer.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid_i && in_ready_o;
      out_taken <= out_valid_o && out_ready_i;
      if (out_valid_o && out_ready_i) begin
        if (levels_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: left %0d right %0d bar %h",
                     out_data_o.left_level, out_data_o.right_level, out_data_o.led_bar);
        end else begin
          want = levels_due.pop_front();
          outstanding--;
          if (out_data_o.left_level !== want.left_level ||
              out_data_o.right_level !== want.right_level ||
              out_data_o.led_bar !== want.led_bar) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: left %0d/%0d right %0d/%0d bar %h/%h (want/got)",
                       want.left_level, out_data_o.left_level,
                       want.right_level, out_data_o.right_level,
                       want.led_bar, out_data_o.led_bar);
          end
        end
      end
      if (in_valid_i && in_ready_o) levels_due.push_back(meter_reading(in_data_i));
    end
  end

  // Sample sender: hold until transfer, then idle for the drawn gap.
  always @(negedge clk_i) begin
    if (in_valid_i && !in_taken) begin
      // hold payload
    end else if (in_gap > 0) begin
      in_valid_i <= 1'b0;
      in_gap--;
    end else if (sample_queue.size() > 0) begin
      in_data_i  <= sample_queue.pop_front();
      in_valid_i <= 1'b1;
      in_gap = idle_on ? $urandom_range(0, 17) : 0;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Result receiver
  always @(negedge clk_i) begin
    if (out_taken) out_wait = idle_on ? $urandom_range(0, 17) : 0;
    if (hold_off) begin
      out_ready_i <= 1'b0;
    end else if (out_wait > 0) begin
      out_ready_i <= 1'b0;
      out_wait--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic logic [9:0] clamp10(int v);
    return (v < 0) ? 10'd0 : (v > 1023) ? 10'd1023 : 10'(v);
  endfunction

  function automatic logic [9:0] wobble(logic [9:0] base, int amp);
    return clamp10(int'(base) + int'($urandom_range(0, 2 * amp)) - amp);
  endfunction

  task automatic offer(int l, int r);
    sample_t s;
    s.left_sample  = 10'(l);
    s.right_sample = 10'(r);
    sample_queue.push_back(s);
    outstanding++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [9:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_BASELINE_LEFT:  baseline_l_reg = val;
      CFG_BASELINE_RIGHT: baseline_r_reg = val;
      CFG_FULL_SCALE:     full_scale_reg = val;
      CFG_NOISE_FLOOR:    noise_reg      = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [9:0] bl, logic [9:0] br, logic [9:0] fs,
                                logic [9:0] nf);
    write_reg(CFG_BASELINE_LEFT, bl);
    write_reg(CFG_BASELINE_RIGHT, br);
    write_reg(CFG_FULL_SCALE, fs);
    write_reg(CFG_NOISE_FLOOR, nf);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Runs of signal shapes around the current baselines, or random or at the rails.
  task automatic queue_samples(int count);
    shape_e shape;
    int     run;
    int     amp;
    int     k;
    k = 0;
    while (k < count) begin
      shape = shape_e'($urandom_range(0, 4));
      run   = $urandom_range(8, 48);
      amp   = $urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(0, 600);
      for (int j = 0; j < run && k < count; j++) begin
        case (shape)
          SHAPE_NOISE:
            offer(int'(wobble(baseline_l_reg, amp)), int'(wobble(baseline_r_reg, amp)));
          SHAPE_SQUARE:
            if (j % 2 == 1)
              offer(int'(clamp10(int'(baseline_l_reg) + amp)),
                    int'(clamp10(int'(baseline_r_reg) - amp)));
            else
              offer(int'(clamp10(int'(baseline_l_reg) - amp)),
                    int'(clamp10(int'(baseline_r_reg) + amp)));
          SHAPE_RANDOM:
            offer($urandom_range(0, 1023), $urandom_range(0, 1023));
          SHAPE_RAILS:
            offer($urandom_range(0, 1) ? 1023 : 0, $urandom_range(0, 1) ? 1023 : 0);
          default:
            offer(int'(baseline_l_reg), int'(baseline_r_reg));
        endcase
        k++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Extremes and edges around the reset baselines
    offer(0, 0);
    offer(1023, 1023);
    offer(512, 512);
    offer(0, 1023);
    offer(1023, 0);
    offer(513, 511);
    offer(511, 513);
    offer(341, 682);
    offer(682, 341);
    offer(514, 510);
    offer(700, 300);
    offer(512, 512);
    offer(1023, 1023);
    offer(0, 0);
    offer(1023, 1023);
    offer(0, 0);
    wait_drained();

    // Long receiver stall while the sender keeps offering
    apply_settings(10'd512, 10'd512, 10'd192, 10'd2);
    queue_samples(300);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
    wait_drained();

    idle_on = 1'b0;
    apply_settings(10'd0, 10'd1023, 10'd1, 10'd0);
    queue_samples(150);
    wait_drained();

    idle_on = 1'b1;
    apply_settings(10'd1023, 10'd0, 10'd1023, 10'd1023);
    queue_samples(150);
    wait_drained();

    // Zero full scale saturates any mean at or above the floor
    apply_settings(10'd512, 10'd512, 10'd0, 10'd0);
    queue_samples(150);
    wait_drained();

    apply_settings(10'd512, 10'd512, 10'd0, 10'd300);
    queue_samples(100);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      apply_settings(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                     10'($urandom_range(0, 1) ? $urandom_range(1, 1023)
                                              : $urandom_range(0, 64)),
                     10'($urandom_range(0, 1) ? $urandom_range(0, 40)
                                              : $urandom_range(0, 1023)));
      queue_samples(110);
      wait_drained();
    end

    repeat (60) @(negedge clk_i);
    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("stereo_vu_meter_envelope_unit_test: done, clean");
    end else begin
      $display("stereo_vu_meter_envelope_unit_test: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("stereo_vu_meter_envelope_unit_test: done, errors");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/svu_pkg.sv
hw/rtl/svu_window_mem.sv
hw/rtl/svu_divider.sv
hw/rtl/svu_bar.sv
hw/rtl/stereo_vu_meter_envelope_unit.sv
test/stereo_vu_meter_envelope_unit_test.sv
